@@ sv/tclr_pkg.sv @@
package tclr_pkg;

    // Field widths of the payload
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 16;
    localparam int CELL_ROW_W = 5;
    localparam int CELL_COL_W = 7;
    localparam int PIXEL_X_W  = 10;
    localparam int PIXEL_Y_W  = 9;
    localparam int CFG_INDEX_W = 2;

    // Character codes and colors
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd0;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 16'h0000;

    // Item kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_FG  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_BG  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_FG = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_BG = 2'd3;

    typedef struct packed {
        logic                  kind;
        logic [CHAR_W-1:0]     char_code;
        logic [CELL_ROW_W-1:0] read_row;
        logic [CELL_COL_W-1:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic                  cell_valid;
        logic                  full_redraw;
        logic [CELL_ROW_W-1:0] cell_row;
        logic [CELL_COL_W-1:0] cell_col;
        logic [CHAR_W-1:0]     cell_char;
        logic [COLOR_W-1:0]    cell_fg;
        logic [COLOR_W-1:0]    cell_bg;
        logic [PIXEL_X_W-1:0]  pixel_x;
        logic [PIXEL_Y_W-1:0]  pixel_y;
    } out_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  code;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } cell_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic access;
        logic clr_setup;
        logic clr_step;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_put;
        logic is_newline;
        logic wrap;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

@@ sv/tclr_ctrl.sv @@
module tclr_ctrl
    import tclr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ACCESS,
        ST_CLR_SETUP,
        ST_CLEAR,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Advance through the phases of one item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    if (sts.is_put && sts.is_newline) state_reg <= ST_CLR_SETUP;
                    else                              state_reg <= ST_ACCESS;
                end
                ST_ACCESS: begin
                    if (sts.is_put && sts.wrap) state_reg <= ST_CLR_SETUP;
                    else                        state_reg <= ST_EMIT;
                end
                ST_CLR_SETUP: begin
                    state_reg <= ST_CLEAR;
                end
                ST_CLEAR: begin
                    if (sts.clr_last) state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (sts.out_free) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Decode commands from the state
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd.load      = s_ready && s_valid;
        cmd.calc      = (state_reg == ST_CALC);
        cmd.access    = (state_reg == ST_ACCESS);
        cmd.clr_setup = (state_reg == ST_CLR_SETUP);
        cmd.clr_step  = (state_reg == ST_CLEAR);
        cmd.emit      = (state_reg == ST_EMIT) && sts.out_free;
    end

endmodule

@@ sv/tclr_datapath.sv @@
module tclr_datapath
    import tclr_pkg::*;
#(
    parameter int COLUMNS      = 72,
    parameter int ROWS         = 30,
    parameter int GLYPH_WIDTH  = 11,
    parameter int GLYPH_HEIGHT = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output status_t                sts,
    input  in_item_t               s_data,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data,
    input  logic                   m_ready,
    output logic                   m_valid,
    output out_item_t              m_data
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int FILL_W = $clog2(COLUMNS + 1);
    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 16;

    // Configuration registers
    logic [COLOR_W-1:0] text_fg_reg, text_bg_reg, blank_fg_reg, blank_bg_reg;

    // Item and per-item working registers
    in_item_t              item_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  in_grid_reg;
    logic                  live_reg;
    logic                  wrap_reg;
    logic [ROW_W-1:0]      dist_reg;
    logic [PIXEL_X_W-1:0]  px_reg;
    logic [PIXEL_Y_W-1:0]  py_reg;
    logic [CELL_ROW_W-1:0] res_row_reg;
    logic [CELL_COL_W-1:0] res_col_reg;
    cell_t                 rdata_reg;

    // Cursor, row state and clear sweep
    logic [ROW_W-1:0]  cursor_row_reg;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [ROWS-1:0]   row_valid_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [COL_W-1:0]  clr_cnt_reg;

    // Output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    cell_t mem [DEPTH];

    logic [ROW_W-1:0]   row_sel, top_row, row_dist;
    logic [COL_W-1:0]   col_sel;
    logic [ROW_W:0]     dist_wide;
    logic [PROD_W-1:0]  px_prod, py_prod;
    logic               in_grid, live, is_read;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    cell_t              mem_wdata;
    out_item_t          result;

    assign is_read = (item_reg.kind == KIND_READ);

    // Select the cell position and work out its screen row distance
    always_comb begin
        row_sel = is_read ? item_reg.read_row[ROW_W-1:0] : cursor_row_reg;
        col_sel = is_read ? item_reg.read_col[COL_W-1:0] : cursor_col_reg;
        top_row = (cursor_row_reg == ROW_W'(ROWS - 1)) ? '0
                                                       : ROW_W'(cursor_row_reg + ROW_W'(1));
        if (row_sel >= top_row)
            dist_wide = (ROW_W+1)'(row_sel) - (ROW_W+1)'(top_row);
        else
            dist_wide = (ROW_W+1)'(row_sel) + (ROW_W+1)'(ROWS) - (ROW_W+1)'(top_row);
        row_dist = dist_wide[ROW_W-1:0];
        px_prod = PROD_W'(col_sel) * PROD_W'(GLYPH_WIDTH);
        py_prod = PROD_W'(dist_reg) * PROD_W'(GLYPH_HEIGHT);
        in_grid = ({1'b0, item_reg.read_row} < (CELL_ROW_W+1)'(ROWS))
               && ({1'b0, item_reg.read_col} < (CELL_COL_W+1)'(COLUMNS));
        // Row zero may hold a partly written line before it is ever cleared
        live    = row_valid_reg[row_sel]
               || ((row_sel == '0) && ({1'b0, item_reg.read_col} < (CELL_COL_W+1)'(fill_reg)));
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_fg_reg  <= COLOR_WHITE;
            text_bg_reg  <= COLOR_BLACK;
            blank_fg_reg <= COLOR_WHITE;
            blank_bg_reg <= COLOR_BLACK;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TEXT_FG:  text_fg_reg  <= cfg_data;
                CFG_TEXT_BG:  text_bg_reg  <= cfg_data;
                CFG_BLANK_FG: blank_fg_reg <= cfg_data;
                CFG_BLANK_BG: blank_bg_reg <= cfg_data;
                default:      text_fg_reg  <= text_fg_reg;
            endcase
        end
    end

    // Latch the item and the per-item address, position and flags
    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_data;
        if (cmd.calc) begin
            addr_reg    <= ADDR_W'(row_sel) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
            in_grid_reg <= in_grid;
            live_reg    <= live;
            wrap_reg    <= (cursor_col_reg == COL_W'(COLUMNS - 1));
            dist_reg    <= row_dist;
            px_reg      <= px_prod[PIXEL_X_W-1:0];
            res_row_reg <= is_read ? item_reg.read_row : CELL_ROW_W'(cursor_row_reg);
            res_col_reg <= is_read ? item_reg.read_col : CELL_COL_W'(cursor_col_reg);
        end
        if (cmd.access) py_reg <= py_prod[PIXEL_Y_W-1:0];
    end

    // Cursor, row valid bits, row zero fill and clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            row_valid_reg  <= '0;
            fill_reg       <= '0;
            clr_cnt_reg    <= '0;
            clr_addr_reg   <= '0;
        end else begin
            if (cmd.access && !is_read) begin
                if (!wrap_reg) cursor_col_reg <= cursor_col_reg + COL_W'(1);
                if (!row_valid_reg[cursor_row_reg]) fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.clr_setup) begin
                cursor_row_reg          <= top_row;
                cursor_col_reg          <= '0;
                row_valid_reg[top_row]  <= 1'b1;
                clr_addr_reg            <= ADDR_W'(top_row) * ADDR_W'(COLUMNS);
                clr_cnt_reg             <= '0;
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                clr_cnt_reg  <= clr_cnt_reg + COL_W'(1);
            end
        end
    end

    // Pick the single write port source
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '{code: item_reg.char_code, fg: text_fg_reg, bg: text_bg_reg};
        if (cmd.access && !is_read) begin
            mem_we = 1'b1;
        end else if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '{code: BLANK_CODE, fg: blank_fg_reg, bg: blank_bg_reg};
        end
    end

    // Cell store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (cmd.access && is_read && in_grid_reg) rdata_reg <= mem[addr_reg];
    end

    // Build the result beat
    always_comb begin
        result = '0;
        if (!is_read) begin
            if (item_reg.char_code == NEWLINE_CODE) begin
                result.full_redraw = 1'b1;
            end else begin
                result.cell_valid  = 1'b1;
                result.full_redraw = wrap_reg;
                result.cell_row    = res_row_reg;
                result.cell_col    = res_col_reg;
                result.cell_char   = item_reg.char_code;
                result.cell_fg     = text_fg_reg;
                result.cell_bg     = text_bg_reg;
                result.pixel_x     = px_reg;
                result.pixel_y     = py_reg;
            end
        end else if (in_grid_reg) begin
            result.cell_valid = 1'b1;
            result.cell_row   = res_row_reg;
            result.cell_col   = res_col_reg;
            if (live_reg) begin
                result.cell_char = rdata_reg.code;
                result.cell_fg   = rdata_reg.fg;
                result.cell_bg   = rdata_reg.bg;
            end
            result.pixel_x = px_reg;
            result.pixel_y = py_reg;
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sts.is_put     = !is_read;
        sts.is_newline = (item_reg.char_code == NEWLINE_CODE);
        sts.wrap       = wrap_reg;
        sts.clr_last   = (clr_cnt_reg == COL_W'(COLUMNS - 1));
        sts.out_free   = !m_valid_reg || m_ready;
    end

endmodule

@@ sv/text_console_line_ring.sv @@
// Text console cell store: a ring of ROWS rows of COLUMNS cells with a cursor.
// Input channel (s_valid/s_ready/s_data): a put beat writes a character at the
// cursor with the current text colors, or starts a new row on newline; a read
// beat looks up one cell. Every input beat gives exactly one result beat on
// the m_ channel, with the cell, buffer and pixel position if the cell is valid.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the text and
// blank colors; cfg_ready is always high, writes are meant for idle periods.
// Items are handled one at a time by a controller and a datapath with a single
// cell memory port. A read or a plain put passes through the calc, access and
// emit states; the next item is taken only after the last one has been emitted.
// Starting a row sweeps it clear at one cell a cycle through the memory write
// port, in the clear state that a newline or a put that wraps passes through.
// s_ready is high only between items.
// The result sits in an output register; while the receiver stalls it holds,
// and the next item may be accepted and worked on, waiting only to load it.
// Reset clears the cursor and the row valid bits and restores white on black
// text and blank colors; no sweep is run at reset, rows that were never
// cleared read as zero.
module text_console_line_ring
    import tclr_pkg::*;
#(
    parameter int COLUMNS      = 72,
    parameter int ROWS         = 30,
    parameter int GLYPH_WIDTH  = 11,
    parameter int GLYPH_HEIGHT = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    tclr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tclr_datapath #(
        .COLUMNS      (COLUMNS),
        .ROWS         (ROWS),
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    // Commands are issued one phase at a time
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.calc, cmd.access, cmd.clr_setup, cmd.clr_step, cmd.emit}))
        else $error("more than one command active");

    // The input is not ready in the cycle after an item is accepted
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    // The clear sweep stops after its last cell
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step && sts.clr_last |=> !cmd.clr_step)
        else $error("clear sweep ran past the row");

    // A reported cell lies inside the grid
    a_cell_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cell_valid |->
            ({1'b0, m_data.cell_row} < (CELL_ROW_W+1)'(ROWS))
            && ({1'b0, m_data.cell_col} < (CELL_COL_W+1)'(COLUMNS)))
        else $error("reported cell outside the grid");

endmodule
